FILE: src/size_class_bitmap_allocator_core_macros.svh
// Assertion macros for the size class bitmap allocator.
// Each use expands to one labeled concurrent assertion on i_clk,
// held off while i_rst_n is low, or to nothing if NO_ASSERTIONS.
`ifndef SIZE_CLASS_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBALC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sbalc: invariant violated");
`define SBALC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbalc: implication violated");
`define SBALC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbalc: next-cycle check violated");
`else
`define SBALC_ASSERT(lbl, prop)
`define SBALC_ASSERT_IMPL(lbl, ante, cons)
`define SBALC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/sbalc_pkg.sv
package sbalc_pkg;

    localparam int WORD_BITS   = 32;  // bitmap bits per memory row
    localparam int BIT_W       = 5;   // bit select within a row
    localparam int MAX_ORDERS  = 8;
    localparam int ORD_W       = 3;
    localparam int NUM_REGS    = 5;
    localparam int SHIFT_W     = 5;
    localparam int FIXED_SHIFT = 31;  // orders without a register
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [2:0] ST_NO_FREE     = 3'd2;
    localparam logic [2:0] ST_BAD_ORDER   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd4;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET [NUM_REGS] =
        '{5'd12, 5'd16, 5'd20, 5'd24, 5'd28};

    typedef struct packed {
        logic             clr;      // 1: clear bit_sel, 0: set first free bit
        logic [BIT_W-1:0] bit_sel;
    } t_scan_req;

    typedef struct packed {
        logic                 found;    // a free bit exists in the masked row
        logic [BIT_W-1:0]     first;    // lowest free bit
        logic                 is_set;   // bit_sel currently used
        logic [WORD_BITS-1:0] word_new; // row after set or clear
    } t_scan_rsp;

    function automatic int f_blocks(int b0, int k);
        return b0 >> (2 * k);
    endfunction

    function automatic int f_rows(int b0, int k);
        return (f_blocks(b0, k) + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic int f_row_base(int b0, int k);
        int acc;
        acc = 0;
        for (int i = 0; i < k; i++) begin
            acc += f_rows(b0, i);
        end
        return acc;
    endfunction

endpackage

FILE: src/sbalc_ram.sv
module sbalc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sbalc_scan.sv
// Shared bitmap row unit: first-free search and single bit set/clear.
module sbalc_scan (
    input  logic [sbalc_pkg::WORD_BITS-1:0] i_word,
    input  logic [sbalc_pkg::WORD_BITS-1:0] i_mask,  // 1 = bit belongs to the order
    input  sbalc_pkg::t_scan_req            i_req,
    output sbalc_pkg::t_scan_rsp            o_rsp
);

    logic [sbalc_pkg::WORD_BITS-1:0] w_eff;
    logic [sbalc_pkg::BIT_W-1:0]     w_first;
    logic                            w_found;

    assign w_eff = i_word | ~i_mask;

    // priority encoder, lowest zero wins
    always_comb begin
        w_first = '0;
        w_found = 1'b0;
        for (int i = sbalc_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!w_eff[i]) begin
                w_first = sbalc_pkg::BIT_W'(i);
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        o_rsp.found  = w_found;
        o_rsp.first  = w_first;
        o_rsp.is_set = i_word[i_req.bit_sel];
        if (i_req.clr) begin
            o_rsp.word_new = i_word & ~(sbalc_pkg::WORD_BITS'(1) << i_req.bit_sel);
        end else begin
            o_rsp.word_new = i_word | (sbalc_pkg::WORD_BITS'(1) << w_first);
        end
    end

endmodule

FILE: src/sbalc_cfg.sv
// Size shift registers behind the APB port.
module sbalc_cfg (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                psel,
    input  logic                                                penable,
    input  logic                                                pwrite,
    input  logic [sbalc_pkg::PADDR_W-1:0]                       paddr,
    input  logic [sbalc_pkg::PDATA_W-1:0]                       pwdata,
    output logic [sbalc_pkg::PDATA_W-1:0]                       prdata,
    output logic                                                pready,
    output logic [sbalc_pkg::NUM_REGS-1:0][sbalc_pkg::SHIFT_W-1:0] o_shift
);

    logic [sbalc_pkg::SHIFT_W-1:0] r_shift [sbalc_pkg::NUM_REGS];
    logic [2:0]                    w_idx;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbalc_pkg::NUM_REGS; i++) begin
                r_shift[i] <= sbalc_pkg::SHIFT_RESET[i];
            end
        end else begin
            for (int i = 0; i < sbalc_pkg::NUM_REGS; i++) begin
                if (w_wr && (w_idx == 3'(i))) begin
                    r_shift[i] <= pwdata[sbalc_pkg::SHIFT_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < sbalc_pkg::NUM_REGS; i++) begin
            o_shift[i] = r_shift[i];
            if (w_idx == 3'(i)) begin
                prdata = sbalc_pkg::PDATA_W'(r_shift[i]);
            end
        end
    end

endmodule

FILE: src/size_class_bitmap_allocator_core.sv
// Allocate: one fit compare per order tried, then one read/check pair per bitmap row read
//           (one 32-bit row per pair, one RAM read port), then the result.
// Free: range checks, row read, used-bit check and clear; bad order/index: checks only.
// Throughput: one request in flight; the next transfer is taken once the result is queued.
// Reset (sync, i_rst_n low): bitmap rows read as zero via per-row valid flops,
// counters clear to zero, size shifts return to 12/16/20/24/28; no clearing pass.
`include "size_class_bitmap_allocator_core_macros.svh"

module size_class_bitmap_allocator_core #(
    parameter int ORDER_COUNT   = 5,
    parameter int BLOCKS_ORDER0 = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_request_size,
    input  logic [2:0]  i_free_order,
    input  logic [10:0] i_free_index,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_granted_order,
    output logic [9:0]  o_granted_index,
    output logic [40:0] o_byte_offset,
    output logic [31:0] o_order_alloc_count,
    output logic [31:0] o_order_free_count,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbalc_pkg::PADDR_W-1:0]     paddr,
    input  logic [sbalc_pkg::PDATA_W-1:0]     pwdata,
    output logic [sbalc_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    // ---------------------------------------------------------------------
    // Geometry. Every order starts on its own bitmap row; rows of all orders
    // sit back to back in ascending order, so fallback to a higher order is
    // just continuing the row walk.
    // ---------------------------------------------------------------------
    localparam int ROWS0      = sbalc_pkg::f_rows(BLOCKS_ORDER0, 0);
    localparam int TOTAL_ROWS = sbalc_pkg::f_row_base(BLOCKS_ORDER0, ORDER_COUNT);
    localparam int ROW_W      = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int RCNT_W     = $clog2(TOTAL_ROWS + 1);
    localparam int WORD_W     = (ROWS0 > 1) ? $clog2(ROWS0) : 1;
    localparam int IDXF_W     = WORD_W + sbalc_pkg::BIT_W;
    localparam int OFF_W      = IDXF_W + (2 ** sbalc_pkg::SHIFT_W) - 1;
    localparam int BLK_W      = $clog2(BLOCKS_ORDER0 + 1);

    localparam logic [2:0] ST_OK          = sbalc_pkg::ST_OK;
    localparam logic [2:0] ST_TOO_LARGE   = sbalc_pkg::ST_TOO_LARGE;
    localparam logic [2:0] ST_NO_FREE     = sbalc_pkg::ST_NO_FREE;
    localparam logic [2:0] ST_BAD_ORDER   = sbalc_pkg::ST_BAD_ORDER;
    localparam logic [2:0] ST_BAD_INDEX   = sbalc_pkg::ST_BAD_INDEX;
    localparam logic [2:0] ST_DOUBLE_FREE = sbalc_pkg::ST_DOUBLE_FREE;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,  // take a request
        S_FIT  = 7'b0000010,  // one size compare per order
        S_RD   = 7'b0000100,  // bitmap row read in flight
        S_ACHK = 7'b0001000,  // allocate: search row, set bit
        S_FCHK = 7'b0010000,  // free: range checks, row address
        S_FUPD = 7'b0100000,  // free: check used bit, clear it
        S_DONE = 7'b1000000   // wait for the result register
    } t_state;

    t_state r_state;

    // per-order constants and live shifts
    logic [BLK_W-1:0]              w_blocks   [sbalc_pkg::MAX_ORDERS];
    logic [RCNT_W-1:0]             w_rows     [sbalc_pkg::MAX_ORDERS];
    logic [ROW_W-1:0]              w_row_base [sbalc_pkg::MAX_ORDERS];
    logic [sbalc_pkg::SHIFT_W-1:0] w_shift    [sbalc_pkg::MAX_ORDERS];
    logic [sbalc_pkg::NUM_REGS-1:0][sbalc_pkg::SHIFT_W-1:0] w_cfg_shift;

    // request context
    logic                         r_free;
    logic [31:0]                  r_size;
    logic [2:0]                   r_forder;
    logic [10:0]                  r_fidx;
    logic [sbalc_pkg::ORD_W-1:0]  r_ord;
    logic [ROW_W-1:0]             r_row;
    logic [WORD_W-1:0]            r_word;   // row within the current order
    logic [sbalc_pkg::BIT_W-1:0]  r_bit;
    logic [2:0]                   r_st;
    logic                         r_gok;    // allocation granted
    logic                         r_zc;     // report zero counters

    logic [TOTAL_ROWS-1:0]        r_vld;    // row written since reset
    logic [31:0]                  r_acnt [sbalc_pkg::MAX_ORDERS];
    logic [31:0]                  r_fcnt [sbalc_pkg::MAX_ORDERS];

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [2:0]  r_out_granted_order;
    logic [9:0]  r_out_granted_index;
    logic [40:0] r_out_byte_offset;
    logic [31:0] r_out_acnt;
    logic [31:0] r_out_fcnt;

    logic [sbalc_pkg::WORD_BITS-1:0] w_ram_q;
    logic [sbalc_pkg::WORD_BITS-1:0] w_rdata;
    logic [sbalc_pkg::WORD_BITS-1:0] w_mask;
    logic [BLK_W-1:0]                w_rem;
    sbalc_pkg::t_scan_req            w_req;
    sbalc_pkg::t_scan_rsp            w_rsp;
    logic                            w_we;
    logic                            w_fit;
    logic                            w_last_word;
    logic                            w_bad_order;
    logic                            w_bad_index;
    logic [31:0]                     w_cnt_inc;
    logic [IDXF_W-1:0]               w_idx;
    logic [OFF_W-1:0]                w_off;
    logic                            w_out_free;
    logic                            w_out_err;
    logic                            w_out_nogrant;
    logic                            w_out_global;
    logic                            w_out_zero_cnt;

    for (genvar k = 0; k < sbalc_pkg::MAX_ORDERS; k++) begin : g_ord
        assign w_blocks[k]   = BLK_W'(sbalc_pkg::f_blocks(BLOCKS_ORDER0, k));
        assign w_rows[k]     = RCNT_W'(sbalc_pkg::f_rows(BLOCKS_ORDER0, k));
        assign w_row_base[k] = ROW_W'(sbalc_pkg::f_row_base(BLOCKS_ORDER0, k));
        if (k < sbalc_pkg::NUM_REGS) begin : g_reg
            assign w_shift[k] = w_cfg_shift[k];
        end else begin : g_fixed
            assign w_shift[k] = sbalc_pkg::SHIFT_W'(sbalc_pkg::FIXED_SHIFT);
        end
    end

    sbalc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_shift (w_cfg_shift)
    );

    // bitmap store, one row per entry; read address is always r_row
    sbalc_ram #(
        .WIDTH (sbalc_pkg::WORD_BITS),
        .DEPTH (TOTAL_ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_rsp.word_new),
        .i_raddr (r_row),
        .o_rdata (w_ram_q)
    );

    // rows never written read as all free
    assign w_rdata = r_vld[r_row] ? w_ram_q : '0;

    // blocks of this order still left from the current row onward; bits past
    // the order's block count are treated as used
    assign w_rem = w_blocks[r_ord] - BLK_W'({r_word, {sbalc_pkg::BIT_W{1'b0}}});
    always_comb begin
        if (32'(w_rem) >= 32'(sbalc_pkg::WORD_BITS)) begin
            w_mask = '1;
        end else begin
            w_mask = sbalc_pkg::WORD_BITS'((33'd1 << w_rem) - 33'd1);
        end
    end

    assign w_req.clr     = r_free;
    assign w_req.bit_sel = r_bit;

    sbalc_scan u_scan (
        .i_word (w_rdata),
        .i_mask (w_mask),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // bitmap write and counter bump always go together
    assign w_we = ((r_state == S_ACHK) && w_rsp.found) ||
                  ((r_state == S_FUPD) && w_rsp.is_set);
    assign w_cnt_inc = (r_free ? r_fcnt[r_ord] : r_acnt[r_ord]) + 32'd1;

    // size fit: request_size <= 1 << shift
    assign w_fit = ({1'b0, r_size} <= (33'd1 << w_shift[r_ord]));

    assign w_last_word = ((RCNT_W'(r_word) + RCNT_W'(1)) == w_rows[r_ord]);
    assign w_bad_order = ({1'b0, r_forder} >= 4'(ORDER_COUNT));
    assign w_bad_index = (32'(r_fidx) >= 32'(w_blocks[r_forder]));

    assign w_idx = {r_word, r_bit};
    assign w_off = OFF_W'(w_idx) << w_shift[r_ord];

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_vld       <= '0;
            for (int i = 0; i < sbalc_pkg::MAX_ORDERS; i++) begin
                r_acnt[i] <= '0;
                r_fcnt[i] <= '0;
            end
        end else begin
            // the done state reloads the result register itself
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_vld[r_row] <= 1'b1;
                if (r_free) begin
                    r_fcnt[r_ord] <= w_cnt_inc;
                end else begin
                    r_acnt[r_ord] <= w_cnt_inc;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_free   <= i_req_type;
                        r_size   <= i_request_size;
                        r_forder <= i_free_order;
                        r_fidx   <= i_free_index;
                        r_ord    <= '0;
                        r_word   <= '0;
                        r_gok    <= 1'b0;
                        r_zc     <= 1'b0;
                        r_state  <= i_req_type ? S_FCHK : S_FIT;
                    end
                end
                S_FIT: begin
                    if (w_fit) begin
                        if (w_rows[r_ord] == '0) begin
                            // empty order: every order above it is empty too
                            r_st    <= ST_NO_FREE;
                            r_zc    <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_row   <= w_row_base[r_ord];
                            r_word  <= '0;
                            r_state <= S_RD;
                        end
                    end else if (r_ord == sbalc_pkg::ORD_W'(ORDER_COUNT - 1)) begin
                        r_st    <= ST_TOO_LARGE;
                        r_zc    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_ord <= r_ord + sbalc_pkg::ORD_W'(1);
                    end
                end
                S_RD: begin
                    r_state <= r_free ? S_FUPD : S_ACHK;
                end
                S_ACHK: begin
                    if (w_rsp.found) begin
                        r_bit   <= w_rsp.first;
                        r_st    <= ST_OK;
                        r_gok   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_row == ROW_W'(TOTAL_ROWS - 1)) begin
                        r_st    <= ST_NO_FREE;
                        r_zc    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        if (w_last_word) begin
                            r_ord  <= r_ord + sbalc_pkg::ORD_W'(1);
                            r_word <= '0;
                        end else begin
                            r_word <= r_word + WORD_W'(1);
                        end
                        r_state <= S_RD;
                    end
                end
                S_FCHK: begin
                    if (w_bad_order) begin
                        r_st    <= ST_BAD_ORDER;
                        r_zc    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_ord <= r_forder;
                        if (w_bad_index) begin
                            r_st    <= ST_BAD_INDEX;
                            r_state <= S_DONE;
                        end else begin
                            r_row   <= w_row_base[r_forder] +
                                       ROW_W'(r_fidx >> sbalc_pkg::BIT_W);
                            r_bit   <= r_fidx[sbalc_pkg::BIT_W-1:0];
                            r_state <= S_RD;
                        end
                    end
                end
                S_FUPD: begin
                    r_st    <= w_rsp.is_set ? ST_OK : ST_DOUBLE_FREE;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out_status        <= r_st;
                        r_out_granted_order <= r_gok ? r_ord : 3'd0;
                        r_out_granted_index <= r_gok ? 10'(w_idx) : 10'd0;
                        r_out_byte_offset   <= r_gok ? 41'(w_off) : 41'd0;
                        r_out_acnt          <= r_zc ? 32'd0 : r_acnt[r_ord];
                        r_out_fcnt          <= r_zc ? 32'd0 : r_fcnt[r_ord];
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_granted_order     = r_out_granted_order;
    assign o_granted_index     = r_out_granted_index;
    assign o_byte_offset       = r_out_byte_offset;
    assign o_order_alloc_count = r_out_acnt;
    assign o_order_free_count  = r_out_fcnt;

    // terms for the result checks below
    assign w_out_err      = r_out_valid && (r_out_status != ST_OK);
    assign w_out_nogrant  = (r_out_granted_order == 3'd0) && (r_out_granted_index == 10'd0) &&
                            (r_out_byte_offset == 41'd0);
    assign w_out_global   = r_out_valid && ((r_out_status == ST_TOO_LARGE) ||
                            (r_out_status == ST_NO_FREE) || (r_out_status == ST_BAD_ORDER));
    assign w_out_zero_cnt = (r_out_acnt == 32'd0) && (r_out_fcnt == 32'd0);

    // row pointer never leaves the bitmap
    `SBALC_ASSERT(a_row_range, r_row <= ROW_W'(TOTAL_ROWS - 1))
    // a bitmap update is always followed by the result stage
    `SBALC_ASSERT_NEXT(a_write_then_done, w_we, r_state == S_DONE)
    // results are only loaded out of the done state
    `SBALC_ASSERT_IMPL(a_load_from_done, $rose(r_out_valid), $past(r_state == S_DONE))
    // a failed result carries no grant
    `SBALC_ASSERT_IMPL(a_no_grant_on_error, w_out_err, w_out_nogrant)
    // global failures report zero counters
    `SBALC_ASSERT_IMPL(a_zero_counts, w_out_global, w_out_zero_cnt)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ORDERS        = 5;
    localparam int BLOCKS_ORDER0 = 1024;
    localparam int BACKLOG_DEPTH = 4;    // requests queued ahead of the driver
    localparam int HOLD_CYCLES   = 250;  // long receiver hold-off
    localparam int HOLD_MARK_A   = 300;  // transfer counts that start a hold-off
    localparam int HOLD_MARK_B   = 650;
    localparam int DRAIN_CYCLES  = 150;  // idle time after the drain, before the final verdict

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [2:0] ST_OK          = sbalc_pkg::ST_OK;
    localparam logic [2:0] ST_TOO_LARGE   = sbalc_pkg::ST_TOO_LARGE;
    localparam logic [2:0] ST_NO_FREE     = sbalc_pkg::ST_NO_FREE;
    localparam logic [2:0] ST_BAD_ORDER   = sbalc_pkg::ST_BAD_ORDER;
    localparam logic [2:0] ST_BAD_INDEX   = sbalc_pkg::ST_BAD_INDEX;
    localparam logic [2:0] ST_DOUBLE_FREE = sbalc_pkg::ST_DOUBLE_FREE;

    localparam int REG_ORDER0_SHIFT = 0;
    localparam int REG_ORDER4_SHIFT = 4;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_size;
        logic [2:0]  free_order;
        logic [10:0] free_index;
    } t_alloc_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  granted_order;
        logic [9:0]  granted_index;
        logic [40:0] byte_offset;
        logic [31:0] ord_acnt;
        logic [31:0] ord_fcnt;
    } t_alloc_rsp;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    t_alloc_req bus_req = '0;
    wire        o_stall;
    wire        o_valid;
    wire [2:0]  o_status;
    wire [2:0]  o_granted_order;
    wire [9:0]  o_granted_index;
    wire [40:0] o_byte_offset;
    wire [31:0] o_order_alloc_count;
    wire [31:0] o_order_free_count;

    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [sbalc_pkg::PADDR_W-1:0]     paddr   = '0;
    logic [sbalc_pkg::PDATA_W-1:0]     pwdata  = '0;
    wire  [sbalc_pkg::PDATA_W-1:0]     prdata;
    wire                               pready;

    size_class_bitmap_allocator_core #(
        .ORDER_COUNT   (ORDERS),
        .BLOCKS_ORDER0 (BLOCKS_ORDER0)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_req_type          (bus_req.req_type),
        .i_request_size      (bus_req.request_size),
        .i_free_order        (bus_req.free_order),
        .i_free_index        (bus_req.free_index),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_granted_order     (o_granted_order),
        .o_granted_index     (o_granted_index),
        .o_byte_offset       (o_byte_offset),
        .o_order_alloc_count (o_order_alloc_count),
        .o_order_free_count  (o_order_free_count),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Allocator shadow: shifts, used bitmaps, per-order counters
    // ------------------------------------------------------------------
    logic [4:0]               shift_cfg [ORDERS];
    logic [BLOCKS_ORDER0-1:0] used_map  [ORDERS];
    logic [31:0]              alloc_cnt [ORDERS];
    logic [31:0]              free_cnt  [ORDERS];

    t_alloc_req req_backlog  [$];  // requests waiting for the driver
    t_alloc_rsp due_outcomes [$];  // predicted results, oldest first

    int n_issued   = 0;  // requests put on the bus (driver)
    int n_accepted = 0;  // request transfers seen (monitor)
    int mismatches = 0;
    int gap_left   = 0;
    int burst_left = 0;
    int hold_left  = 0;
    int held_at    = -1;
    int rx_cycle   = 0;

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Applies one request to the shadow state and returns the result it should give.
    function automatic t_alloc_rsp allocate_or_free(input t_alloc_req rq);
        t_alloc_rsp r;
        int         fit;
        int         k;
        int         i;
        int         blocks;
        bit         placed;
        r = '0;
        if (rq.req_type == REQ_ALLOC) begin
            // lowest order whose block covers the size; shifts need not rise
            fit = ORDERS;
            for (k = ORDERS - 1; k >= 0; k--)
                if ({1'b0, rq.request_size} <= (33'd1 << shift_cfg[k]))
                    fit = k;
            if (fit == ORDERS) begin
                r.status = ST_TOO_LARGE;
            end else begin
                // fall back upward through the orders until one has a free block
                r.status = ST_NO_FREE;
                placed   = 1'b0;
                for (k = fit; k < ORDERS && !placed; k++) begin
                    blocks = BLOCKS_ORDER0 >> (2 * k);
                    for (i = 0; i < blocks && !placed; i++) begin
                        if (!used_map[k][i]) begin
                            used_map[k][i]  = 1'b1;
                            alloc_cnt[k]    = alloc_cnt[k] + 32'd1;
                            r.status        = ST_OK;
                            r.granted_order = k[2:0];
                            r.granted_index = i[9:0];
                            r.byte_offset   = 41'(i) << shift_cfg[k];
                            r.ord_acnt      = alloc_cnt[k];
                            r.ord_fcnt      = free_cnt[k];
                            placed          = 1'b1;
                        end
                    end
                end
            end
        end else if (rq.free_order >= ORDERS) begin
            r.status = ST_BAD_ORDER;
        end else begin
            k = int'(rq.free_order);
            if (rq.free_index >= (BLOCKS_ORDER0 >> (2 * k))) begin
                r.status = ST_BAD_INDEX;
            end else if (!used_map[k][rq.free_index]) begin
                r.status = ST_DOUBLE_FREE;
            end else begin
                used_map[k][rq.free_index] = 1'b0;
                free_cnt[k] = free_cnt[k] + 32'd1;
                r.status    = ST_OK;
            end
            r.ord_acnt = alloc_cnt[k];
            r.ord_fcnt = free_cnt[k];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, payload held while stalled
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && n_accepted != n_issued) begin
            // transfer still pending, keep valid and payload as they are
        end else if (gap_left != 0) begin
            i_valid  <= 1'b0;
            gap_left = gap_left - 1;
        end else if (req_backlog.size() != 0) begin
            bus_req  <= req_backlog.pop_front();
            i_valid  <= 1'b1;
            n_issued = n_issued + 1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(12, 1);
                gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            end else begin
                burst_left = burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Long hold-off: once at each mark the receiver stops taking results
    // while the driver keeps offering, so the block backs up into o_stall.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((n_accepted == HOLD_MARK_A || n_accepted == HOLD_MARK_B)
                     && n_accepted != held_at) begin
            hold_left <= HOLD_CYCLES;
            held_at   <= n_accepted;
        end
    end

    // Receiver stall pattern; the mode follows bits 8:6 of the cycle counter
    always @(negedge i_clk) begin : receiver
        logic pat;
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:6]) inside
            3'd1, 3'd5: pat = ($urandom_range(3, 0) == 0);
            3'd2:       pat = ($urandom_range(9, 0) < 6);
            3'd4:       pat = (rx_cycle % 3 == 0);
            3'd6:       pat = (rx_cycle % 7 < 2);
            3'd7:       pat = ($urandom_range(1, 0) == 1);
            default:    pat = 1'b0;
        endcase
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= pat || (hold_left != 0);
    end

    // ------------------------------------------------------------------
    // Monitor: checks result transfers, predicts on request transfers.
    // Results are checked before the new prediction is queued.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_alloc_rsp want;
        t_alloc_rsp got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_granted_order, o_granted_index, o_byte_offset,
                   o_order_alloc_count, o_order_free_count};
            if (due_outcomes.size() == 0) begin
                flag_mismatch("unrequested result, status", '0, 64'(got.status));
            end else begin
                want = due_outcomes.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 64'(want.status), 64'(got.status));
                if (got.granted_order !== want.granted_order)
                    flag_mismatch("granted_order", 64'(want.granted_order),
                                  64'(got.granted_order));
                if (got.granted_index !== want.granted_index)
                    flag_mismatch("granted_index", 64'(want.granted_index),
                                  64'(got.granted_index));
                if (got.byte_offset !== want.byte_offset)
                    flag_mismatch("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
                if (got.ord_acnt !== want.ord_acnt)
                    flag_mismatch("order_alloc_count", 64'(want.ord_acnt), 64'(got.ord_acnt));
                if (got.ord_fcnt !== want.ord_fcnt)
                    flag_mismatch("order_free_count", 64'(want.ord_fcnt), 64'(got.ord_fcnt));
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            due_outcomes.push_back(allocate_or_free(bus_req));
            n_accepted = n_accepted + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(input t_alloc_req rq);
        while (req_backlog.size() >= BACKLOG_DEPTH)
            @(negedge i_clk);
        req_backlog.push_back(rq);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || n_accepted != n_issued || due_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    // One APB transfer: setup, access, done at the edge with pready high
    task automatic cfg_access(input logic wr, input int reg_idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= sbalc_pkg::PADDR_W'(reg_idx * 4);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic verify_shifts();
        int          r;
        logic [31:0] rd;
        for (r = REG_ORDER0_SHIFT; r <= REG_ORDER4_SHIFT; r++) begin
            cfg_access(1'b0, r, '0, rd);
            if (rd[4:0] !== shift_cfg[r])
                flag_mismatch("shift register readback", 64'(shift_cfg[r]), 64'(rd));
        end
    endtask

    function automatic t_alloc_req alloc_of(input logic [31:0] size);
        t_alloc_req rq;
        rq              = '0;
        rq.req_type     = REQ_ALLOC;
        rq.request_size = size;
        return rq;
    endfunction

    function automatic t_alloc_req free_of(input int ord, input int idx);
        t_alloc_req rq;
        rq            = '0;
        rq.req_type   = REQ_FREE;
        rq.free_order = 3'(ord);
        rq.free_index = 11'(idx);
        return rq;
    endfunction

    // Mostly well-formed traffic: allocations aimed at an order, frees of
    // blocks that are held, plus some double frees and malformed frees.
    // Fields a request ignores carry random noise.
    function automatic t_alloc_req random_request();
        t_alloc_req  rq;
        int unsigned roll;
        int          tgt;
        int          k;
        int          j;
        int          i;
        int          ord;
        int          idx;
        int          blocks;
        int          start;
        bit          found;
        logic [32:0] lim;
        rq.req_type     = REQ_ALLOC;
        rq.request_size = $urandom;
        rq.free_order   = 3'($urandom_range(7, 0));
        rq.free_index   = 11'($urandom_range(2047, 0));
        roll = $urandom_range(99, 0);
        if (roll < 62) begin
            roll = $urandom_range(99, 0);
            tgt  = (roll < 15) ? 0 : (roll < 50) ? 1 : (roll < 70) ? 2 : (roll < 85) ? 3 : 4;
            lim  = 33'd1 << shift_cfg[tgt];
            roll = $urandom_range(99, 0);
            if (roll < 35)
                rq.request_size = lim[31:0];          // exactly the block size
            else if (roll < 45)
                rq.request_size = lim[31:0] + 32'd1;  // one byte over
            else if (roll < 50)
                rq.request_size = '0;
            else if (roll >= 55)
                rq.request_size = $urandom_range(lim[31:0], 0);
        end else if (roll < 90) begin
            rq.req_type   = REQ_FREE;
            k             = $urandom_range(ORDERS - 1, 0);
            rq.free_order = 3'(k);
            rq.free_index = 11'($urandom_range((BLOCKS_ORDER0 >> (2 * k)) - 1, 0));
            found = 1'b0;
            for (j = 0; j < ORDERS && !found; j++) begin
                ord    = (k + j) % ORDERS;
                blocks = BLOCKS_ORDER0 >> (2 * ord);
                start  = $urandom_range(blocks - 1, 0);
                for (i = 0; i < blocks && !found; i++) begin
                    idx = (start + i) % blocks;
                    if (used_map[ord][idx]) begin
                        rq.free_order = 3'(ord);
                        rq.free_index = 11'(idx);
                        found         = 1'b1;
                    end
                end
            end
        end else if (roll < 94) begin
            rq.req_type   = REQ_FREE;
            k             = $urandom_range(ORDERS - 1, 0);
            rq.free_order = 3'(k);
            rq.free_index = 11'($urandom_range((BLOCKS_ORDER0 >> (2 * k)) - 1, 0));
        end else if (roll < 97) begin
            rq.req_type   = REQ_FREE;
            k             = $urandom_range(ORDERS - 1, 0);
            rq.free_order = 3'(k);
            rq.free_index = 11'($urandom_range(2047, BLOCKS_ORDER0 >> (2 * k)));
        end else begin
            rq.req_type   = REQ_FREE;
            rq.free_order = 3'($urandom_range(7, ORDERS));
        end
        return rq;
    endfunction

    // Shifts are packed with order 4 in the top field.
    task automatic run_round(input logic [ORDERS-1:0][4:0] shifts, input int count);
        int          r;
        int          n;
        logic [31:0] rd;
        wait_drained();
        for (r = REG_ORDER0_SHIFT; r <= REG_ORDER4_SHIFT; r++) begin
            cfg_access(1'b1, r, 32'(shifts[r]), rd);
            shift_cfg[r] = shifts[r];
        end
        verify_shifts();
        for (n = 0; n < count; n++)
            queue_request(random_request());
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [ORDERS-1:0][4:0] rnd_shifts;
        int                     k;
        int                     rnd;
        for (k = 0; k < ORDERS; k++) begin
            shift_cfg[k] = sbalc_pkg::SHIFT_RESET[k];
            used_map[k]  = '0;
            alloc_cnt[k] = '0;
            free_cnt[k]  = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        verify_shifts();

        // Directed part at reset shifts 12/16/20/24/28
        queue_request(alloc_of(32'd0));              // zero size lands in order 0
        queue_request(alloc_of(32'd4096));           // exact order 0 block
        queue_request(alloc_of(32'd4097));           // one over, goes to order 1
        queue_request(alloc_of(32'hFFFF_FFFF));      // too large
        queue_request(alloc_of(32'h1000_0001));      // just past the largest order
        for (k = 0; k < 4; k++)
            queue_request(alloc_of(32'h1000_0000));  // fill order 4
        queue_request(alloc_of(32'h1000_0000));      // order 4 full, nothing above
        queue_request(free_of(4, 2));
        queue_request(alloc_of(32'h1000_0000));      // reuses the freed slot
        queue_request(free_of(0, 1));
        queue_request(free_of(0, 1));                // double free
        queue_request(free_of(0, 1023));             // never allocated
        queue_request(free_of(0, 1024));             // bad index
        queue_request(free_of(4, 2047));             // bad index, all index bits set
        queue_request(free_of(5, 0));                // bad order
        queue_request(free_of(7, 0));                // bad order
        queue_request(free_of(3, 15));               // never allocated
        queue_request(alloc_of(32'd1));              // first free order 0 slot
        queue_request(alloc_of(32'h0001_0000));      // exact order 1 block

        // Random rounds, each under its own shift setting
        run_round({5'd31, 5'd31, 5'd31, 5'd31, 5'd31}, 180);
        run_round({5'd0, 5'd0, 5'd0, 5'd0, 5'd0}, 60);
        run_round({5'd31, 5'd25, 5'd17, 5'd9, 5'd3}, 250);  // small top orders fill up
        run_round({5'd12, 5'd0, 5'd31, 5'd5, 5'd20}, 200);  // shifts out of order
        for (rnd = 0; rnd < 2; rnd++) begin
            for (k = 0; k < ORDERS; k++)
                rnd_shifts[k] = 5'($urandom_range(31, 0));
            run_round(rnd_shifts, 150);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
